// File: src/qpht_pkg.sv
// Package with the types, constants and codes of the quadratic probe hash table.
`timescale 1ns / 1ps
package qpht_pkg;
    localparam int MaxSlots = 256;
    localparam int SlotW = $clog2(MaxSlots);
    localparam int CntW = SlotW + 1;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED = 2'd1;
    localparam logic [1:0] MARK_GONE = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_FOUND = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DELETED = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0] func;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] slot_index;
        logic [8:0] probe_count;
        logic [8:0] stored_count;
    } rsp_t;
endpackage

// File: src/qpht_if.sv
// Valid-ready channel interface carrying one payload per transfer.
`timescale 1ns / 1ps
interface qpht_if #(parameter type payload_t = logic) ();
    logic valid;
    logic ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/qpht_mod.sv
// Restoring modulo unit: one quotient bit a cycle of a 32-bit magnitude by the table size.
`timescale 1ns / 1ps
module qpht_mod
    import qpht_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [31:0]     dividend,
    input  logic [CntW-1:0] divisor,
    output logic            done,
    output logic [SlotW-1:0] remainder
);
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] shifted;

    always_comb
    begin
        shifted = {rem_reg[31:0], quo_reg[31]};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (shifted >= {24'd0, divisor})
                rem_next = shifted - {24'd0, divisor};
            else
                rem_next = shifted;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd1) && !start;
    assign remainder = rem_next[SlotW-1:0];
endmodule

// File: src/quadratic_probe_hash_table_core.sv
// Top level of the quadratic probe hash table: sequencer, slot memories and channels.
//
// Items arrive on the req channel (func, item_value) and one result leaves on
// the rsp channel for each item: status, slot_index, probe_count and
// stored_count. The user must write table_size through cfg_we and cfg_wdata
// only while idle; the block itself does not enforce this. Each item first
// goes through the bit-serial modulo of the magnitude by the table size, then
// each slot is probed in a read state (memory read) and a check state (compare
// and step), and an output state issues the result. A delete on an empty table
// skips the probing. The registered read of the slot memories sets the probe
// rate. The block takes one item at a time; req ready is high only when it is
// idle and the result register is free. After reset a clearing pass marks
// every slot empty, during which no item is accepted. If the receiver stalls,
// the result waits in the output register and the next item is not taken
// until it is transferred.
`timescale 1ns / 1ps
module quadratic_probe_hash_table_core
    import qpht_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [8:0]     cfg_wdata,
    qpht_if.sink           req,
    qpht_if.source         rsp
);
    state_t state_reg, state_next;
    logic [8:0] size_reg;
    logic [CntW-1:0] n_reg;
    logic [1:0] func_reg;
    logic [31:0] val_reg;
    logic [CntW-1:0] i_reg, i_next;
    logic [CntW-1:0] pos_reg, pos_next;
    logic [CntW:0] step_reg, step_next;
    logic [CntW-1:0] cnt_reg;
    logic [SlotW-1:0] clr_reg;
    logic out_valid_reg;
    rsp_t out_reg;

    logic [1:0] marks_mem [MaxSlots];
    logic [31:0] values_mem [MaxSlots];
    logic [1:0] mark_rd_reg;
    logic [31:0] value_rd_reg;

    logic mod_start, mod_done;
    logic [SlotW-1:0] mod_rem;
    logic [31:0] mag;
    logic [CntW-1:0] n_eff;
    logic fin;
    logic [2:0] fin_status;
    logic wr_en;
    logic [1:0] wr_mark;
    logic [SlotW-1:0] wr_addr;
    logic take;

    assign mag = req.payload.item_value[31] ? (32'd0 - req.payload.item_value)
                                            : req.payload.item_value;
    assign n_eff = (size_reg == 9'd0) ? 9'd1 :
                   (size_reg > 9'(MaxSlots)) ? 9'(MaxSlots) : size_reg;
    assign take = req.valid && req.ready;
    assign mod_start = take;

    qpht_mod u_mod
    (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(mag),
        .divisor(n_eff), .done(mod_done), .remainder(mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == SlotW'(MaxSlots - 1)) state_next = S_IDLE;
            S_IDLE:
                if (take)
                    state_next = S_MOD;
            S_MOD:
                if (mod_done)
                    state_next = (func_reg == FUNC_DELETE && cnt_reg == '0) ? S_OUT : S_READ;
            S_READ: state_next = S_CHECK;
            S_CHECK: state_next = fin ? S_OUT : S_READ;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Probe decision on the slot just read, and the slot clearing writes after reset.
    always_comb
    begin
        fin = 1'b0;
        fin_status = ST_NOT_FOUND;
        wr_en = 1'b0;
        wr_mark = MARK_EMPTY;
        wr_addr = pos_reg[SlotW-1:0];
        if (state_reg == S_CLEAR)
        begin
            wr_en = 1'b1;
            wr_addr = clr_reg;
        end
        else if (state_reg == S_CHECK)
        begin
            if (func_reg == FUNC_INSERT)
            begin
                if (mark_rd_reg == MARK_EMPTY || mark_rd_reg == MARK_GONE)
                begin
                    fin = 1'b1;
                    fin_status = ST_INSERTED;
                    wr_en = 1'b1;
                    wr_mark = MARK_USED;
                end
                else if (i_reg == n_reg - 9'd1)
                begin
                    fin = 1'b1;
                    fin_status = ST_FULL;
                end
            end
            else
            begin
                if (mark_rd_reg == MARK_EMPTY)
                    fin = 1'b1;
                else if (mark_rd_reg == MARK_USED && value_rd_reg == val_reg)
                begin
                    fin = 1'b1;
                    fin_status = (func_reg == FUNC_DELETE) ? ST_DELETED : ST_FOUND;
                    if (func_reg == FUNC_DELETE)
                    begin
                        wr_en = 1'b1;
                        wr_mark = MARK_GONE;
                    end
                end
                else if (i_reg == n_reg - 9'd1)
                    fin = 1'b1;
            end
        end
    end

    // Next probe: pos + (2i+1) mod n, with the step 2i+1 kept reduced mod n.
    always_comb
    begin
        logic [CntW:0] sum;
        logic [CntW:0] st2;
        sum = {1'b0, pos_reg} + step_reg;
        if (sum >= {1'b0, n_reg}) sum = sum - {1'b0, n_reg};
        st2 = step_reg + 10'd2;
        if (st2 >= {1'b0, n_reg}) st2 = st2 - {1'b0, n_reg};
        pos_next = sum[CntW-1:0];
        step_next = st2;
        i_next = i_reg + 9'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            size_reg <= 9'd256;
            cnt_reg <= '0;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) size_reg <= cfg_wdata;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + SlotW'(1);
            if (rsp.valid && rsp.ready) out_valid_reg <= 1'b0;
            if (state_reg == S_OUT) out_valid_reg <= 1'b1;
            if (fin && fin_status == ST_INSERTED) cnt_reg <= cnt_reg + 9'd1;
            if (fin && fin_status == ST_DELETED) cnt_reg <= cnt_reg - 9'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg <= req.payload.func;
            val_reg <= req.payload.item_value;
            n_reg <= n_eff;
        end
        if (state_reg == S_MOD && mod_done)
        begin
            pos_reg <= {1'b0, mod_rem};
            i_reg <= '0;
            step_reg <= (n_reg == 9'd1) ? 10'd0 : 10'd1;
            out_reg <= '{ST_EMPTY, 8'd0, 9'd0, cnt_reg};
        end
        if (state_reg == S_CHECK)
        begin
            if (fin)
            begin
                out_reg.status <= fin_status;
                out_reg.slot_index <= (fin_status == ST_NOT_FOUND || fin_status == ST_FULL)
                                      ? 8'd0 : 8'(pos_reg);
                out_reg.probe_count <= (fin_status == ST_FULL
                                        || (fin_status == ST_NOT_FOUND
                                            && mark_rd_reg != MARK_EMPTY)) ? n_reg : i_reg;
            end
            else
            begin
                pos_reg <= pos_next;
                step_reg <= step_next;
                i_reg <= i_next;
            end
        end
        if (state_reg == S_OUT)
            out_reg.stored_count <= cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            marks_mem[wr_addr] <= wr_mark;
        if (state_reg == S_CHECK && fin_status == ST_INSERTED && fin)
            values_mem[wr_addr] <= val_reg;
        mark_rd_reg <= marks_mem[pos_reg[SlotW-1:0]];
        value_rd_reg <= values_mem[pos_reg[SlotW-1:0]];
    end

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("ready high while an item is in work");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 9'(MaxSlots))
        else $error("stored count beyond table capacity");
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> rsp.valid)
        else $error("result not presented after completion");
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the quadratic probe hash table core.
`timescale 1ns / 1ps
module tb_top;
    import qpht_pkg::*;

    localparam logic [1:0] FUNC_SEARCH = 2'd2;
    localparam logic [1:0] FUNC_SEARCH_ALT = 2'd3;
    localparam int CycleLimit = 3000000;

    class hash_scoreboard;
        logic [1:0] marks[MaxSlots];
        logic [31:0] values[MaxSlots];
        int unsigned count;
        logic [8:0] size_reg;
        rsp_t pending[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned status_seen[6];

        function new();
            foreach (marks[k]) marks[k] = MARK_EMPTY;
            foreach (values[k]) values[k] = '0;
            count = 0;
            size_reg = 9'd256;
            errors = 0;
            checked = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function int unsigned slot_of(int unsigned home, int unsigned i, int unsigned n);
            longint unsigned sq;
            sq = longint'(i) * longint'(i);
            return int'((longint'(home) + sq) % longint'(n));
        endfunction

        function void note_request(req_t r);
            logic [31:0] v;
            logic [31:0] mag;
            int unsigned n;
            int unsigned home;
            int unsigned i;
            int unsigned idx;
            bit hit;
            rsp_t e;
            v = r.item_value;
            mag = v[31] ? (32'd0 - v) : v;
            n = (size_reg == 0) ? 1 : ((size_reg > MaxSlots) ? MaxSlots : size_reg);
            home = mag % n;
            e = '0;
            hit = 0;
            if (r.func == FUNC_INSERT) begin
                e.status = ST_FULL;
                for (i = 0; i < n; i++) begin
                    idx = slot_of(home, i, n);
                    if (marks[idx] != MARK_USED) begin
                        values[idx] = v;
                        marks[idx] = MARK_USED;
                        count++;
                        e.status = ST_INSERTED;
                        e.slot_index = idx[7:0];
                        break;
                    end
                end
                e.probe_count = i[8:0];
            end else if (r.func == FUNC_DELETE && count == 0) begin
                e.status = ST_EMPTY;
            end else begin
                for (i = 0; i < n; i++) begin
                    idx = slot_of(home, i, n);
                    if (marks[idx] == MARK_EMPTY) break;
                    if (marks[idx] == MARK_USED && values[idx] == v) begin
                        hit = 1;
                        break;
                    end
                end
                e.probe_count = i[8:0];
                if (!hit) begin
                    e.status = ST_NOT_FOUND;
                end else if (r.func == FUNC_DELETE) begin
                    marks[idx] = MARK_GONE;
                    values[idx] = '0;
                    count--;
                    e.status = ST_DELETED;
                    e.slot_index = idx[7:0];
                end else begin
                    e.status = ST_FOUND;
                    e.slot_index = idx[7:0];
                end
            end
            e.stored_count = count[8:0];
            pending.push_back(e);
        endfunction

        function void check_result(rsp_t a);
            rsp_t e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: %p", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.status < 6) status_seen[e.status]++;
            if (a.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, a.status);
                errors++;
            end
            if (a.slot_index !== e.slot_index) begin
                $error("slot_index expected %0d actual %0d", e.slot_index, a.slot_index);
                errors++;
            end
            if (a.probe_count !== e.probe_count) begin
                $error("probe_count expected %0d actual %0d", e.probe_count, a.probe_count);
                errors++;
            end
            if (a.stored_count !== e.stored_count) begin
                $error("stored_count expected %0d actual %0d", e.stored_count, a.stored_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [8:0] cfg_wdata;
    int unsigned cycles;
    bit long_stalls;
    int unsigned sizes_used;
    hash_scoreboard board;
    logic [31:0] recent[$];

    qpht_if #(.payload_t(req_t)) req_ch ();
    qpht_if #(.payload_t(rsp_t)) rsp_ch ();

    quadratic_probe_hash_table_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(req_ch.sink),
        .rsp(rsp_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        cycles = 0;
        long_stalls = 0;
        sizes_used = 0;
    end

    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("[quadratic_probe_hash_table_core] ERROR");
            $finish;
        end
    end

    // Receiver side: random back-pressure while long_stalls is set, checks each completed transfer.
    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.payload);
            if (hold > 0) begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end else if (long_stalls && $urandom_range(0, 3) == 0) begin
                hold = gap_length();
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Valid stays high from one transfer to the next unless a gap is inserted;
    // drain drops it once the last item has gone.
    task automatic send_item(logic [1:0] f, logic [31:0] v);
        int unsigned g;
        g = long_stalls ? gap_length() : 0;
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= '{func: f, item_value: v};
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        board.note_request(req_ch.payload);
        if (recent.size() > 40) void'(recent.pop_front());
        recent.push_back(v);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_size(logic [8:0] s);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.size_reg = s;
        sizes_used++;
    endtask

    function automatic logic [31:0] pick_value(int unsigned n);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4 && recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
        if (r < 8) begin
            logic [31:0] m;
            m = $urandom_range(0, 3 * n);
            return $urandom_range(0, 1) ? -m : m;
        end
        return $urandom();
    endfunction

    task automatic random_phase(int unsigned items, int unsigned n, int unsigned ins_weight);
        int unsigned r;
        logic [1:0] f;
        repeat (items) begin
            r = $urandom_range(0, 99);
            if (r < ins_weight) f = FUNC_INSERT;
            else if (r < ins_weight + (100 - ins_weight) / 2) f = FUNC_DELETE;
            else if (r < 97) f = FUNC_SEARCH;
            else f = FUNC_SEARCH_ALT;
            send_item(f, pick_value(n));
        end
    endtask

    initial
    begin
        @(posedge clk);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default size, extremes of value, every operation.
        send_item(FUNC_DELETE, 32'd5);
        send_item(FUNC_SEARCH, 32'd5);
        send_item(FUNC_INSERT, 32'h8000_0000);
        send_item(FUNC_INSERT, 32'h7FFF_FFFF);
        send_item(FUNC_INSERT, 32'h8000_0001);
        send_item(FUNC_INSERT, 32'd0);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF);
        send_item(FUNC_INSERT, 32'd1);
        send_item(FUNC_INSERT, 32'd1);
        send_item(FUNC_SEARCH, 32'h8000_0000);
        send_item(FUNC_SEARCH_ALT, 32'd1);
        send_item(FUNC_DELETE, 32'd1);
        send_item(FUNC_SEARCH, 32'd1);
        send_item(FUNC_DELETE, 32'd1);
        send_item(FUNC_DELETE, 32'd1);
        send_item(FUNC_INSERT, 32'd257);
        send_item(FUNC_SEARCH, 32'd12345);

        // Size zero acts as one: the table fills at once.
        write_size(9'd0);
        send_item(FUNC_INSERT, 32'd77);
        send_item(FUNC_INSERT, 32'd78);
        send_item(FUNC_SEARCH, 32'd99);
        // Size above the maximum, and the table left in place after a change.
        write_size(9'd511);
        send_item(FUNC_SEARCH, 32'd77);
        send_item(FUNC_DELETE, 32'h8000_0000);
        write_size(9'd1);
        send_item(FUNC_INSERT, 32'd3);
        send_item(FUNC_DELETE, 32'd3);

        long_stalls = 1;
        write_size(9'd7);
        random_phase(150, 7, 60);
        write_size(9'd2);
        random_phase(60, 2, 50);
        write_size(9'd16);
        random_phase(300, 16, 55);
        // The sender waits for every result before carrying on.
        drain();
        write_size(9'd13);
        random_phase(250, 13, 50);
        long_stalls = 0;
        write_size(9'd5);
        random_phase(150, 5, 65);
        long_stalls = 1;
        write_size(9'd256);
        random_phase(200, 256, 70);
        write_size(9'd32);
        random_phase(300, 32, 50);
        write_size(9'd300);
        random_phase(80, 256, 40);

        drain();
        repeat (600) @(posedge clk);
        $display("Covered %0d results over %0d table sizes, with stalls on both channels.",
                 board.checked, sizes_used);
        $display("Status counts: ins %0d full %0d found %0d miss %0d del %0d empty %0d",
                 board.status_seen[0], board.status_seen[1], board.status_seen[2],
                 board.status_seen[3], board.status_seen[4], board.status_seen[5]);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[quadratic_probe_hash_table_core] OK");
        end else begin
            $display("[quadratic_probe_hash_table_core] ERROR");
        end
        $finish;
    end
endmodule

// File: sim.f
src/qpht_pkg.sv
src/qpht_if.sv
src/qpht_mod.sv
src/quadratic_probe_hash_table_core.sv
tb/tb_top.sv
